// ----- rtl/core/nearest_point_search_macros.svh -----
// Assertion macros used by the checker file of the nearest point search.
`ifndef NEAREST_POINT_SEARCH_MACROS_SVH
`define NEAREST_POINT_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/nps_pkg.sv -----
package nps_pkg;

    // Fixed field widths of the beats.
    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int DIST_W   = 25;
    localparam int THR_W    = 25;
    localparam int INDEX_W  = 10;

    localparam int CAPACITY_DEFAULT = 1024;

    // Action codes.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [THR_W-1:0]          stop_threshold;
    } nps_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic [DIST_W-1:0]  best_distance;
        logic               found;
        logic               table_full;
    } nps_out_t;

    // Kind of result the datapath builds when the controller loads the output.
    typedef enum logic [2:0] {
        RES_INSERT,
        RES_FULL,
        RES_EMPTY,
        RES_QUERY,
        RES_CLEAR,
        RES_ZERO
    } nps_res_kind_t;

    typedef struct packed {
        logic          load_in;
        logic          rd_en;
        logic          sqrt_start;
        logic          load_out;
        logic          write_pt;
        logic          clr_count;
        nps_res_kind_t res_kind;
    } nps_cmd_t;

    typedef struct packed {
        logic stop_hit;
        logic pipe_busy;
        logic sqrt_done;
    } nps_sts_t;

endpackage

// ----- rtl/core/nps_isqrt.sv -----
// Restoring integer square root, one result bit per cycle.
module nps_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nps_pkg::SUM_W-1:0] value,
    output logic [nps_pkg::ROOT_W-1:0] root,
    output logic                      done
);

    localparam int RW    = nps_pkg::ROOT_W;
    localparam int VW    = nps_pkg::SUM_W;
    localparam int REM_W = RW + 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [VW-1:0]    val_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [RW-1:0]    root_reg;
    logic [RW-1:0]    root_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;

    // Bring down the next pair of bits and try to subtract 4r+1.
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], val_reg[VW-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[RW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[RW-2:0], 1'b0};
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Working registers of the root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[VW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ----- rtl/core/nps_datapath.sv -----
// Point store, distance pipeline, best-point tracking and result register.
module nps_datapath #(
    parameter int CAPACITY = nps_pkg::CAPACITY_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nps_pkg::nps_in_t              in_data,
    input  nps_pkg::nps_cmd_t             cmd,
    input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
    output logic [$clog2(CAPACITY):0]     count,
    output nps_pkg::nps_sts_t             sts,
    output nps_pkg::nps_out_t             out_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CW    = nps_pkg::COORD_W;
    localparam int DW    = nps_pkg::DIFF_W;
    localparam int SQW   = nps_pkg::SQ_W;
    localparam int SW    = nps_pkg::SUM_W;
    localparam int RTW   = nps_pkg::ROOT_W;
    localparam int DSW   = nps_pkg::DIST_W;
    localparam int OIW   = nps_pkg::INDEX_W;
    localparam int EW    = (IDX_W > OIW) ? IDX_W : OIW;

    logic signed [CW-1:0] mem_x [CAPACITY];
    logic signed [CW-1:0] mem_y [CAPACITY];
    logic signed [CW-1:0] mem_z [CAPACITY];

    nps_pkg::nps_in_t     q_reg;
    logic [SQW-1:0]       thr_sq_reg;
    logic [IDX_W:0]       count_reg;

    logic                 v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]     idx0_reg, idx1_reg, idx2_reg, idx3_reg;
    logic signed [CW-1:0] px_reg, py_reg, pz_reg;
    logic [DW-1:0]        ax_reg, ay_reg, az_reg;
    logic [SQW-1:0]       sx_reg, sy_reg, sz_reg;
    logic [SW-1:0]        sum_reg;

    logic                 have_reg;
    logic [SW-1:0]        best_reg;
    logic [IDX_W-1:0]     best_idx_reg;

    logic signed [DW-1:0] dx, dy, dz;
    logic                 stop_hit;
    logic                 take;
    logic [RTW-1:0]       root;
    logic                 sqrt_done;
    nps_pkg::nps_out_t    out_reg;
    nps_pkg::nps_out_t    out_next;
    logic [EW-1:0]        count_ext;
    logic [EW-1:0]        best_ext;

    // Query registers; the threshold is squared once per query.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            q_reg      <= in_data;
            thr_sq_reg <= SQW'(in_data.stop_threshold) * SQW'(in_data.stop_threshold);
        end
    end

    // Fill count of the point store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load_out && cmd.clr_count)
        begin
            count_reg <= '0;
        end
        else if (cmd.load_out && cmd.write_pt)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // Point store: one write port for inserts, one registered read port for scans.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out && cmd.write_pt)
        begin
            mem_x[count_reg[IDX_W-1:0]] <= q_reg.pos_x;
            mem_y[count_reg[IDX_W-1:0]] <= q_reg.pos_y;
            mem_z[count_reg[IDX_W-1:0]] <= q_reg.pos_z;
        end
        if (cmd.rd_en)
        begin
            px_reg <= mem_x[rd_addr];
            py_reg <= mem_y[rd_addr];
            pz_reg <= mem_z[rd_addr];
        end
    end

    // Coordinate differences against the query point.
    always_comb
    begin
        dx = DW'(px_reg) - DW'(q_reg.pos_x);
        dy = DW'(py_reg) - DW'(q_reg.pos_y);
        dz = DW'(pz_reg) - DW'(q_reg.pos_z);
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.rd_en;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Distance stages: magnitude, square, sum.
    always_ff @(posedge clk)
    begin
        idx0_reg <= rd_addr;
        idx1_reg <= idx0_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        ax_reg   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay_reg   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
        az_reg   <= dz[DW-1] ? DW'(-dz) : DW'(dz);
        sx_reg   <= SQW'(ax_reg) * SQW'(ax_reg);
        sy_reg   <= SQW'(ay_reg) * SQW'(ay_reg);
        sz_reg   <= SQW'(az_reg) * SQW'(az_reg);
        sum_reg  <= SW'(sx_reg) + SW'(sy_reg) + SW'(sz_reg);
    end

    // Once the best is under the threshold, later points are ignored.
    assign stop_hit = have_reg && (best_reg < SW'(thr_sq_reg));
    assign take     = v3_reg && !stop_hit && (!have_reg || (sum_reg < best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (cmd.load_in)
        begin
            have_reg <= 1'b0;
        end
        else if (take)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg     <= sum_reg;
            best_idx_reg <= idx3_reg;
        end
    end

    nps_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value (best_reg),
        .root  (root),
        .done  (sqrt_done)
    );

    assign count_ext = EW'(count_reg[IDX_W-1:0]);
    assign best_ext  = EW'(best_idx_reg);

    // Result fields for the kind of beat being finished.
    always_comb
    begin
        out_next = '0;
        case (cmd.res_kind)
            nps_pkg::RES_INSERT:
            begin
                out_next.entry_index = count_ext[OIW-1:0];
                out_next.found       = 1'b1;
            end
            nps_pkg::RES_FULL:
            begin
                out_next.table_full = 1'b1;
            end
            nps_pkg::RES_EMPTY:
            begin
                out_next.best_distance = '1;
            end
            nps_pkg::RES_QUERY:
            begin
                out_next.entry_index   = best_ext[OIW-1:0];
                out_next.best_distance = (|root[RTW-1:DSW]) ? '1 : root[DSW-1:0];
                out_next.found         = 1'b1;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign count         = count_reg;
    assign sts.stop_hit  = stop_hit;
    assign sts.pipe_busy = v0_reg | v1_reg | v2_reg | v3_reg;
    assign sts.sqrt_done = sqrt_done;
    assign out_data      = out_reg;

endmodule

// ----- rtl/core/nps_ctrl.sv -----
// Sequencer for insert, query and clear items, and the output valid flag.
module nps_ctrl #(
    parameter int CAPACITY = nps_pkg::CAPACITY_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  logic [$clog2(CAPACITY):0]   count,
    input  nps_pkg::nps_sts_t           sts,
    output nps_pkg::nps_cmd_t           cmd,
    output logic [$clog2(CAPACITY)-1:0] rd_addr
);

    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ROOT,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    nps_pkg::nps_res_kind_t kind_reg, kind_next;
    logic [IDX_W-1:0]       scan_addr_reg, scan_addr_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   scan_last;

    assign scan_last = ({1'b0, scan_addr_reg} == (count - 1'b1));

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        scan_addr_next = scan_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_kind   = kind_reg;
        in_ready       = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_FINISH;
                    case (action)
                        nps_pkg::ACT_INSERT:
                        begin
                            kind_next = (count >= (IDX_W + 1)'(CAPACITY)) ?
                                        nps_pkg::RES_FULL : nps_pkg::RES_INSERT;
                        end
                        nps_pkg::ACT_QUERY:
                        begin
                            if (count == '0)
                            begin
                                kind_next = nps_pkg::RES_EMPTY;
                            end
                            else
                            begin
                                kind_next      = nps_pkg::RES_QUERY;
                                scan_addr_next = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        nps_pkg::ACT_CLEAR:
                        begin
                            kind_next = nps_pkg::RES_CLEAR;
                        end
                        default:
                        begin
                            kind_next = nps_pkg::RES_ZERO;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // One stored point read per cycle.
                cmd.rd_en      = 1'b1;
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_last || sts.stop_hit)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (sts.sqrt_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.write_pt   = (kind_reg == nps_pkg::RES_INSERT);
                    cmd.clr_count  = (kind_reg == nps_pkg::RES_CLEAR);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= nps_pkg::RES_ZERO;
            scan_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            scan_addr_reg <= scan_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rd_addr   = scan_addr_reg;
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/nearest_point_search.sv -----
// Nearest point search over a table of up to CAPACITY 3D points. An insert beat
// stores a point and returns its index, a query beat returns the index of the
// nearest stored point (with early stop, the best one scanned before the stop)
// and the truncated root of its squared distance, and a clear beat empties the
// table. One beat is processed at a time. The store has one read port, so the
// query scan reads one point per cycle and stops early once the early-stop
// threshold is met; then a 4-stage distance pipeline drains and a square root
// unit produces one result bit per cycle. A finished result waits in an output
// register.
module nearest_point_search #(
    parameter int CAPACITY = nps_pkg::CAPACITY_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nps_pkg::nps_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nps_pkg::nps_out_t out_data
);

    localparam int IDX_W = $clog2(CAPACITY);

    nps_pkg::nps_cmd_t  cmd;
    nps_pkg::nps_sts_t  sts;
    logic [IDX_W:0]     count;
    logic [IDX_W-1:0]   rd_addr;

    nps_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (in_data.action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .count     (count),
        .sts       (sts),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    nps_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .count    (count),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

// ----- rtl/core/nps_checker.sv -----
`include "nearest_point_search_macros.svh"

// Port-level checks of the nearest point search.
module nps_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input nps_pkg::nps_out_t out_data
);

    // A result beat stays until taken.
    `NPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

    // The block works on one beat at a time.
    `NPS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                     "beat accepted while busy")

    // A dropped insert never reports success.
    `NPS_ASSERT_NOW(a_full_not_found, out_valid && out_data.table_full, !out_data.found,
                    "full and found together")

    // Without a found point the index is zero.
    `NPS_ASSERT_NOW(a_index_zero, out_valid && !out_data.found, out_data.entry_index == '0,
                    "index set without a found point")

endmodule

bind nearest_point_search nps_checker u_nps_checker (.*);
